// ===== src/wmta_pkg.sv =====
// ---------------------------------------------------------------------------
// wmta_pkg - shared types and constants for the weighted matching improver
// Field widths, request codes, sequencer states and small helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package wmta_pkg;

  localparam int TYPE_W   = 3;
  localparam int SLOT_W   = 14;
  localparam int ID_W     = 11;
  localparam int WEIGHT_W = 32;
  localparam int GAIN_W   = WEIGHT_W + 3;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_ADJ_DEF      = 8192;

  typedef logic [TYPE_W-1:0]          req_code_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [ID_W-1:0]            vid_t;
  typedef logic [WEIGHT_W-1:0]        weight_t;
  typedef logic signed [GAIN_W-1:0]   gain_t;

  localparam req_code_t REQ_LOAD_ROW  = 3'd0;
  localparam req_code_t REQ_LOAD_ADJ  = 3'd1;
  localparam req_code_t REQ_LOAD_MATE = 3'd2;
  localparam req_code_t REQ_PROCESS   = 3'd3;
  localparam req_code_t REQ_READ      = 3'd4;

  localparam vid_t VCOUNT_RST = 11'd1024;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_VR1, ST_VR2, ST_SR1, ST_SR2,
    ST_MK_RD, ST_MK_WR,
    ST_C4_RD, ST_C4_X, ST_C4_M, ST_C4_G,
    ST_A_RD, ST_A_X, ST_A_G,
    ST_P_RD, ST_P_X, ST_P_G,
    ST_DEC, ST_RW_RD, ST_RW_WR, ST_RW_SX, ST_RW_SY,
    ST_F0, ST_F1, ST_F2
  } state_t;

  // Vertex number in use, else none.
  function automatic vid_t vid(vid_t x, vid_t n);
    return (x != '0 && x <= n) ? x : '0;
  endfunction

  function automatic gain_t sx(weight_t w);
    return {{(GAIN_W-WEIGHT_W){w[WEIGHT_W-1]}}, w};
  endfunction

endpackage

`default_nettype wire

// ===== src/wmta_in_if.sv =====
// ---------------------------------------------------------------------------
// wmta_in_if - request channel
// Valid/ready channel carrying one request item.
// ---------------------------------------------------------------------------
`default_nettype none

interface wmta_in_if;
  logic                    valid;
  logic                    ready;
  wmta_pkg::req_code_t     req_type;
  wmta_pkg::slot_t         slot;
  wmta_pkg::vid_t          vertex_id;
  wmta_pkg::slot_t         row_start;
  logic signed [wmta_pkg::WEIGHT_W-1:0] edge_weight;

  modport source (output valid, req_type, slot, vertex_id, row_start, edge_weight,
                  input ready);
  modport sink   (input valid, req_type, slot, vertex_id, row_start, edge_weight,
                  output ready);
endinterface

`default_nettype wire

// ===== src/wmta_out_if.sv =====
// ---------------------------------------------------------------------------
// wmta_out_if - result channel
// Valid/ready channel carrying one result item.
// ---------------------------------------------------------------------------
`default_nettype none

interface wmta_out_if;
  logic                    valid;
  logic                    ready;
  logic                    changed;
  wmta_pkg::vid_t          vertex_partner;
  logic signed [wmta_pkg::WEIGHT_W-1:0] partner_weight;
  wmta_pkg::vid_t          old_partner;
  wmta_pkg::vid_t          old_partner_new_mate;
  logic                    fault;

  modport source (output valid, changed, vertex_partner, partner_weight, old_partner,
                  old_partner_new_mate, fault, input ready);
  modport sink   (input valid, changed, vertex_partner, partner_weight, old_partner,
                  old_partner_new_mate, fault, output ready);
endinterface

`default_nettype wire

// ===== src/weighted_matching_two_augment.sv =====
// ---------------------------------------------------------------------------
// weighted_matching_two_augment - matching improver by 2-augmentation
// Holds a graph in compressed rows plus a matching in on-chip memories and
// improves the matching one requested vertex at a time.
// ---------------------------------------------------------------------------
//
//  channel   direction  handshake       carries
//  in_ch     sink       valid/ready     req_type, slot, vertex_id, row_start,
//                                       edge_weight
//  out_ch    source     valid/ready     changed, vertex_partner, partner_weight,
//                                       old_partner, old_partner_new_mate, fault
//  cfg_*     sink       write enable    vertex_count (11 bits)
//
//  Load items, spare-code items and items naming no vertex are answered straight from
//  idle. A read item passes states F0, F1 and F2. A process item walks the rows of
//  v and of its partner s1 one entry at a time through the single read port of the
//  adjacency and partner memories, then rewires when the matching improves.
//  After reset the mark owner memory is cleared, one entry a cycle, entries 0
//  to MAX_VERTICES; no item is accepted meanwhile.
//  A stalled result holds in the output register; a new item is taken once
//  that register is free or drains in the same cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_matching_two_augment #(
  parameter int MAX_VERTICES = wmta_pkg::MAX_VERTICES_DEF,
  parameter int MAX_ADJ      = wmta_pkg::MAX_ADJ_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  wmta_in_if.sink                in_ch,
  wmta_out_if.source             out_ch,
  input  wire                    cfg_we,
  input  wire [wmta_pkg::ID_W-1:0] cfg_wdata
);
  import wmta_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES + 2);
  localparam int AW = $clog2(MAX_ADJ);
  localparam int JW = $clog2(MAX_ADJ + 1);

  // Row bounds: cap the end at the adjacency depth, clamp a reversed row.
  function automatic logic [JW-1:0] row_hi(slot_t hi);
    return (32'(hi) > 32'(MAX_ADJ)) ? JW'(MAX_ADJ) : JW'(hi);
  endfunction

  function automatic logic [JW-1:0] row_lo(slot_t lo, logic [JW-1:0] hj);
    return (32'(lo) > 32'(hj)) ? hj : JW'(lo);
  endfunction

  // ---- memories --------------------------------------------------------
  slot_t   rs_mem     [0:MAX_VERTICES+1];
  vid_t    adj_v_mem  [0:MAX_ADJ-1];
  weight_t adj_w_mem  [0:MAX_ADJ-1];
  vid_t    mate_mem   [0:MAX_VERTICES];
  weight_t mw_mem     [0:MAX_VERTICES];
  vid_t    mk_own_mem [0:MAX_VERTICES];
  weight_t mk_w_mem   [0:MAX_VERTICES];

  logic          rs_re, rs_we;
  logic [VW-1:0] rs_ra, rs_wa;
  slot_t         rs_wd, rs_q;

  logic          adj_re, adj_we;
  logic [AW-1:0] adj_ra, adj_wa;
  vid_t          adj_v_wd, adj_v_q;
  weight_t       adj_w_wd, adj_w_q;

  logic          mate_re, mate_we, mw_we;
  logic [VW-1:0] mate_ra, mate_wa, mw_wa;
  vid_t          mate_wd, mate_q;
  weight_t       mw_wd, mw_q;

  logic          mk_re, mk_we;
  logic [VW-1:0] mk_ra, mk_wa;
  vid_t          mk_own_wd, mk_own_q;
  weight_t       mk_w_wd, mk_w_q;

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    if (rs_re) rs_q <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_v_mem[adj_wa] <= adj_v_wd;
      adj_w_mem[adj_wa] <= adj_w_wd;
    end
    if (adj_re) begin
      adj_v_q <= adj_v_mem[adj_ra];
      adj_w_q <= adj_w_mem[adj_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (mate_we) mate_mem[mate_wa] <= mate_wd;
    if (mw_we)   mw_mem[mw_wa]     <= mw_wd;
    if (mate_re) begin
      mate_q <= mate_mem[mate_ra];
      mw_q   <= mw_mem[mate_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (mk_we) begin
      mk_own_mem[mk_wa] <= mk_own_wd;
      mk_w_mem[mk_wa]   <= mk_w_wd;
    end
    if (mk_re) begin
      mk_own_q <= mk_own_mem[mk_ra];
      mk_w_q   <= mk_w_mem[mk_ra];
    end
  end

  // ---- control and datapath registers ----------------------------------
  state_t        st_r, st_nxt;
  logic [VW-1:0] clr_r, clr_nxt;
  vid_t          vcount_r, vcount_nxt;
  vid_t          n_used;

  logic [JW-1:0] j_r, j_nxt, bv_r, bv_nxt, ev_r, ev_nxt, bs_r, bs_nxt, es_r, es_nxt;
  slot_t         lo_r, lo_nxt;
  vid_t          v_r, v_nxt, s1_r, s1_nxt, xr_r, xr_nxt, mx_r, mx_nxt;
  weight_t       mwv_r, mwv_nxt;
  gain_t         best_r, best_nxt, w1_r, w1_nxt, w2_r, w2_nxt;
  vid_t          ip_r, ip_nxt, s1p_r, s1p_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  weight_t       wip_r, wip_nxt, ws1p_r, ws1p_nxt, wp1_r, wp1_nxt, wp2_r, wp2_nxt;
  vid_t          rx_r, rx_nxt, ry_r, ry_nxt;
  weight_t       rw_r, rw_nxt;
  logic [1:0]    step_r, step_nxt;
  logic          pend2_r, pend2_nxt, chg_r, chg_nxt, flt_r, flt_nxt;
  vid_t          vp_r, vp_nxt;
  weight_t       pw_r, pw_nxt;

  logic          ov_r, ov_nxt;
  logic          o_chg_r, o_chg_nxt, o_flt_r, o_flt_nxt;
  vid_t          o_vp_r, o_vp_nxt, o_op_r, o_op_nxt, o_onm_r, o_onm_nxt;
  weight_t       o_pw_r, o_pw_nxt;

  logic          out_free;

  assign n_used   = (32'(vcount_r) > 32'(MAX_VERTICES)) ? ID_W'(MAX_VERTICES) : vcount_r;
  assign out_free = !ov_r || out_ch.ready;

  assign in_ch.ready                 = (st_r == ST_IDLE) && out_free;
  assign out_ch.valid                = ov_r;
  assign out_ch.changed              = o_chg_r;
  assign out_ch.vertex_partner       = o_vp_r;
  assign out_ch.partner_weight       = o_pw_r;
  assign out_ch.old_partner          = o_op_r;
  assign out_ch.old_partner_new_mate = o_onm_r;
  assign out_ch.fault                = o_flt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_CLR;
      clr_r    <= '0;
      vcount_r <= VCOUNT_RST;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      clr_r    <= clr_nxt;
      vcount_r <= vcount_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r <= j_nxt;   bv_r <= bv_nxt;   ev_r <= ev_nxt;   bs_r <= bs_nxt;   es_r <= es_nxt;
    lo_r <= lo_nxt; v_r <= v_nxt;     s1_r <= s1_nxt;   xr_r <= xr_nxt;   mx_r <= mx_nxt;
    mwv_r <= mwv_nxt; best_r <= best_nxt; w1_r <= w1_nxt; w2_r <= w2_nxt;
    ip_r <= ip_nxt; s1p_r <= s1p_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
    wip_r <= wip_nxt; ws1p_r <= ws1p_nxt; wp1_r <= wp1_nxt; wp2_r <= wp2_nxt;
    rx_r <= rx_nxt; ry_r <= ry_nxt; rw_r <= rw_nxt; step_r <= step_nxt;
    pend2_r <= pend2_nxt; chg_r <= chg_nxt; flt_r <= flt_nxt;
    vp_r <= vp_nxt; pw_r <= pw_nxt;
    o_chg_r <= o_chg_nxt; o_flt_r <= o_flt_nxt; o_vp_r <= o_vp_nxt;
    o_op_r <= o_op_nxt; o_onm_r <= o_onm_nxt; o_pw_r <= o_pw_nxt;
  end

  // ---- sequencer -------------------------------------------------------
  always_comb begin
    vid_t  x_c, vv_c, up_c;
    gain_t g_c, uw_c, t_c;
    weight_t uwp_c;
    logic  zero_res;

    x_c = vid(adj_v_q, n_used);
    vv_c = vid(in_ch.vertex_id, n_used);
    g_c = sx(adj_w_q) - sx(mw_q);
    up_c = '0; uw_c = '0; uwp_c = '0; t_c = '0;
    zero_res = 1'b0;

    st_nxt = st_r; clr_nxt = clr_r;
    vcount_nxt = cfg_we ? cfg_wdata : vcount_r;
    j_nxt = j_r; bv_nxt = bv_r; ev_nxt = ev_r; bs_nxt = bs_r; es_nxt = es_r;
    lo_nxt = lo_r; v_nxt = v_r; s1_nxt = s1_r; xr_nxt = xr_r; mx_nxt = mx_r;
    mwv_nxt = mwv_r; best_nxt = best_r; w1_nxt = w1_r; w2_nxt = w2_r;
    ip_nxt = ip_r; s1p_nxt = s1p_r; p1_nxt = p1_r; p2_nxt = p2_r;
    wip_nxt = wip_r; ws1p_nxt = ws1p_r; wp1_nxt = wp1_r; wp2_nxt = wp2_r;
    rx_nxt = rx_r; ry_nxt = ry_r; rw_nxt = rw_r; step_nxt = step_r;
    pend2_nxt = pend2_r; chg_nxt = chg_r; flt_nxt = flt_r;
    vp_nxt = vp_r; pw_nxt = pw_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_chg_nxt = o_chg_r; o_flt_nxt = o_flt_r; o_vp_nxt = o_vp_r;
    o_op_nxt = o_op_r; o_onm_nxt = o_onm_r; o_pw_nxt = o_pw_r;

    rs_re = 1'b0; rs_ra = '0; rs_we = 1'b0; rs_wa = '0; rs_wd = in_ch.row_start;
    adj_re = 1'b0; adj_ra = AW'(j_r); adj_we = 1'b0; adj_wa = AW'(in_ch.slot);
    adj_v_wd = in_ch.vertex_id; adj_w_wd = in_ch.edge_weight;
    mate_re = 1'b0; mate_ra = '0;
    mate_we = 1'b0; mate_wa = '0; mate_wd = '0;
    mw_we = 1'b0; mw_wa = '0; mw_wd = '0;
    mk_re = 1'b0; mk_ra = '0; mk_we = 1'b0; mk_wa = VW'(x_c);
    mk_own_wd = v_r; mk_w_wd = adj_w_q;

    unique case (st_r)
      ST_CLR: begin
        mk_we = 1'b1; mk_wa = clr_r; mk_own_wd = '0; mk_w_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == 32'(MAX_VERTICES)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_ch.valid && out_free) begin
          unique case (in_ch.req_type)
            REQ_LOAD_ROW: begin
              rs_we = (32'(in_ch.slot) <= 32'(MAX_VERTICES + 1));
              rs_wa = VW'(in_ch.slot);
              zero_res = 1'b1;
            end
            REQ_LOAD_ADJ: begin
              adj_we = (32'(in_ch.slot) < 32'(MAX_ADJ));
              zero_res = 1'b1;
            end
            REQ_LOAD_MATE: begin
              mate_we = (32'(in_ch.slot) <= 32'(MAX_VERTICES));
              mw_we = mate_we;
              mate_wa = VW'(in_ch.slot); mw_wa = VW'(in_ch.slot);
              mate_wd = in_ch.vertex_id; mw_wd = in_ch.edge_weight;
              zero_res = 1'b1;
            end
            REQ_PROCESS, REQ_READ: begin
              if (vv_c == '0) begin
                zero_res = 1'b1;
              end else begin
                v_nxt = vv_c; chg_nxt = 1'b0; flt_nxt = 1'b0;
                if (in_ch.req_type == REQ_READ) begin
                  s1_nxt = '0;
                  st_nxt = ST_F0;
                end else begin
                  rs_re = 1'b1; rs_ra = VW'(vv_c);
                  mate_re = 1'b1; mate_ra = VW'(vv_c);
                  st_nxt = ST_VR1;
                end
              end
            end
            default: zero_res = 1'b1;
          endcase
          if (zero_res) begin
            ov_nxt = 1'b1;
            o_chg_nxt = 1'b0; o_flt_nxt = 1'b0; o_vp_nxt = '0;
            o_op_nxt = '0; o_onm_nxt = '0; o_pw_nxt = '0;
          end
        end
      end
      ST_VR1: begin
        lo_nxt = rs_q; mwv_nxt = mw_q; best_nxt = sx(mw_q);
        s1_nxt = vid(mate_q, n_used);
        w1_nxt = '0; w2_nxt = '0; p1_nxt = '0; p2_nxt = '0; wp1_nxt = '0; wp2_nxt = '0;
        ip_nxt = '0; s1p_nxt = '0; wip_nxt = '0; ws1p_nxt = '0;
        rs_re = 1'b1; rs_ra = VW'(v_r) + 1'b1;
        st_nxt = ST_VR2;
      end
      ST_VR2: begin
        ev_nxt = row_hi(rs_q); bv_nxt = row_lo(lo_r, row_hi(rs_q));
        rs_re = 1'b1; rs_ra = VW'(s1_r);
        st_nxt = ST_SR1;
      end
      ST_SR1: begin
        lo_nxt = rs_q;
        rs_re = 1'b1; rs_ra = VW'(s1_r) + 1'b1;
        st_nxt = ST_SR2;
      end
      ST_SR2: begin
        es_nxt = row_hi(rs_q); bs_nxt = row_lo(lo_r, row_hi(rs_q));
        j_nxt = bv_r;
        st_nxt = (s1_r != '0) ? ST_MK_RD : ST_A_RD;
      end
      // Mark every neighbor of v with v and the edge weight.
      ST_MK_RD: begin
        if (j_r < ev_r) begin
          adj_re = 1'b1; j_nxt = j_r + 1'b1; st_nxt = ST_MK_WR;
        end else begin
          j_nxt = bs_r; st_nxt = ST_C4_RD;
        end
      end
      ST_MK_WR: begin
        mk_we = (x_c != '0);
        st_nxt = ST_MK_RD;
      end
      // Rings v - s1 - x - mate(x) closing on a marked vertex.
      ST_C4_RD: begin
        if (j_r < es_r) begin
          adj_re = 1'b1; j_nxt = j_r + 1'b1; st_nxt = ST_C4_X;
        end else begin
          j_nxt = bv_r; st_nxt = ST_A_RD;
        end
      end
      ST_C4_X: begin
        if (x_c == '0 || x_c == v_r) begin
          st_nxt = ST_C4_RD;
        end else begin
          xr_nxt = x_c; mate_re = 1'b1; mate_ra = VW'(x_c); st_nxt = ST_C4_M;
        end
      end
      ST_C4_M: begin
        mx_nxt = vid(mate_q, n_used);
        mk_re = 1'b1; mk_ra = VW'(vid(mate_q, n_used));
        st_nxt = ST_C4_G;
      end
      ST_C4_G: begin
        t_c = g_c + sx(mk_w_q);
        if (mk_own_q == v_r && t_c > best_r) begin
          best_nxt = t_c; ip_nxt = mx_r; wip_nxt = mk_w_q;
          s1p_nxt = xr_r; ws1p_nxt = adj_w_q;
        end
        st_nxt = ST_C4_RD;
      end
      // Best and second-best single arms from v.
      ST_A_RD: begin
        if (j_r < ev_r) begin
          adj_re = 1'b1; j_nxt = j_r + 1'b1; st_nxt = ST_A_X;
        end else begin
          if (w1_r > best_r) begin
            best_nxt = w1_r; ip_nxt = p1_r; wip_nxt = wp1_r;
          end
          j_nxt = bs_r;
          st_nxt = (s1_r != '0) ? ST_P_RD : ST_DEC;
        end
      end
      ST_A_X: begin
        if (x_c == '0 || x_c == s1_r) begin
          st_nxt = ST_A_RD;
        end else begin
          xr_nxt = x_c; mate_re = 1'b1; mate_ra = VW'(x_c); st_nxt = ST_A_G;
        end
      end
      ST_A_G: begin
        if (g_c > w2_r) begin
          if (g_c > w1_r) begin
            w2_nxt = w1_r; p2_nxt = p1_r; wp2_nxt = wp1_r;
            w1_nxt = g_c; p1_nxt = xr_r; wp1_nxt = adj_w_q;
          end else begin
            w2_nxt = g_c; p2_nxt = xr_r; wp2_nxt = adj_w_q;
          end
        end
        st_nxt = ST_A_RD;
      end
      // Arm of s1 joined to the best arm of v that avoids it.
      ST_P_RD: begin
        if (j_r < es_r) begin
          adj_re = 1'b1; j_nxt = j_r + 1'b1; st_nxt = ST_P_X;
        end else begin
          st_nxt = ST_DEC;
        end
      end
      ST_P_X: begin
        if (x_c == '0 || x_c == v_r) begin
          st_nxt = ST_P_RD;
        end else begin
          xr_nxt = x_c; mate_re = 1'b1; mate_ra = VW'(x_c); st_nxt = ST_P_G;
        end
      end
      ST_P_G: begin
        if (xr_r == p1_r) begin
          up_c = p2_r; uw_c = w2_r; uwp_c = wp2_r;
        end else begin
          up_c = p1_r; uw_c = w1_r; uwp_c = wp1_r;
        end
        t_c = g_c + uw_c;
        if (!g_c[GAIN_W-1] && t_c > best_r) begin
          best_nxt = t_c; ip_nxt = up_c; wip_nxt = uwp_c;
          s1p_nxt = xr_r; ws1p_nxt = adj_w_q;
        end
        st_nxt = ST_P_RD;
      end
      ST_DEC: begin
        st_nxt = ST_F0;
        if (best_r > sx(mwv_r)) begin
          if (ip_r == s1_r) begin
            flt_nxt = 1'b1;
          end else begin
            chg_nxt = 1'b1; step_nxt = '0;
            if (ip_r != '0) begin
              rx_nxt = v_r; ry_nxt = ip_r; rw_nxt = wip_r;
              pend2_nxt = (s1p_r != '0); st_nxt = ST_RW_RD;
            end else if (s1p_r != '0) begin
              rx_nxt = s1_r; ry_nxt = s1p_r; rw_nxt = ws1p_r;
              pend2_nxt = 1'b0; st_nxt = ST_RW_RD;
            end
          end
        end
      end
      // Rewire: drop old partners of both ends, then pair them.
      ST_RW_RD: begin
        mate_re = 1'b1; mate_ra = step_r[0] ? VW'(ry_r) : VW'(rx_r);
        st_nxt = ST_RW_WR;
      end
      ST_RW_WR: begin
        if (!step_r[1]) begin
          mate_we = 1'b1; mate_wa = VW'(vid(mate_q, n_used));
        end else begin
          mw_we = 1'b1; mw_wa = VW'(vid(mate_q, n_used));
        end
        step_nxt = step_r + 1'b1;
        st_nxt = (step_r == 2'd3) ? ST_RW_SX : ST_RW_RD;
      end
      ST_RW_SX: begin
        mate_we = 1'b1; mate_wa = VW'(rx_r); mate_wd = ry_r;
        mw_we = 1'b1; mw_wa = VW'(rx_r); mw_wd = rw_r;
        st_nxt = ST_RW_SY;
      end
      ST_RW_SY: begin
        mate_we = 1'b1; mate_wa = VW'(ry_r); mate_wd = rx_r;
        mw_we = 1'b1; mw_wa = VW'(ry_r); mw_wd = rw_r;
        if (pend2_r) begin
          rx_nxt = s1_r; ry_nxt = s1p_r; rw_nxt = ws1p_r;
          step_nxt = '0; pend2_nxt = 1'b0; st_nxt = ST_RW_RD;
        end else begin
          st_nxt = ST_F0;
        end
      end
      ST_F0: begin
        mate_re = 1'b1; mate_ra = VW'(v_r); st_nxt = ST_F1;
      end
      ST_F1: begin
        vp_nxt = mate_q; pw_nxt = mw_q;
        mate_re = 1'b1; mate_ra = VW'(s1_r); st_nxt = ST_F2;
      end
      ST_F2: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          o_chg_nxt = chg_r; o_flt_nxt = flt_r; o_vp_nxt = vp_r; o_pw_nxt = pw_r;
          o_op_nxt = s1_r;
          o_onm_nxt = (s1_r != '0) ? vid(mate_q, n_used) : '0;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/wmta_checker.sv =====
// ---------------------------------------------------------------------------
// wmta_checker - port-level checks for the matching improver
// Watches the result channel and reset behavior.
// ---------------------------------------------------------------------------
`default_nettype none

module wmta_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_changed,
  input wire        out_fault,
  input wire [10:0] out_vertex_partner
);

  // A stalled result stays valid with its partner unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_partner))
    else $error("stalled result changed");

  // No result right after reset.
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A fault keeps the matching.
  a_fault_nochg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fault |-> !out_changed)
    else $error("fault with change");

endmodule

bind weighted_matching_two_augment wmta_checker u_wmta_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_changed        (out_ch.changed),
  .out_fault          (out_ch.fault),
  .out_vertex_partner (out_ch.vertex_partner)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top - regression bench for the weighted matching improver
// Loads small graphs and matchings over the request channel. Each vertex that
// is processed or read uses only stores loaded beforehand. A built-in
// predictor checks every result item field by field. Both channel sides
// stall at random, except while calm is set.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import wmta_pkg::*;

  localparam int NV   = MAX_VERTICES_DEF;
  localparam int NADJ = MAX_ADJ_DEF;

  typedef struct packed {
    req_code_t   kind;
    slot_t       slot;
    vid_t        id;
    slot_t       rs;
    logic [31:0] w;
  } request_t;

  typedef struct packed {
    logic        changed;
    vid_t        partner;
    logic [31:0] pw;
    vid_t        oldp;
    vid_t        oldp_mate;
    logic        fault;
  } result_t;

  // Request codes the block ignores, answering with an all-zero result.
  localparam req_code_t REQ_SPARE_LO = 3'd5;
  localparam req_code_t REQ_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [ID_W-1:0] cfg_wdata;

  wmta_in_if  in_if ();
  wmta_out_if out_if ();

  weighted_matching_two_augment dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Predictor copy of the block's stores and register.
  logic [SLOT_W-1:0] row_tab [0:NV+1];
  vid_t              adj_to  [0:NADJ-1];
  longint            adj_w   [0:NADJ-1];
  vid_t              mate_tab[0:NV];
  longint            mate_w  [0:NV];
  vid_t              mark_by [0:NV];
  longint            mark_w  [0:NV];
  logic [ID_W-1:0]   vcount_reg = VCOUNT_RST;

  request_t request_q[$];
  result_t  pending_results[$];
  bit       in_took = 1'b0;
  bit       calm = 1'b0;
  int       errors = 0;
  int       n_items = 0, n_proc = 0, n_changed = 0, n_fault = 0, n_reads = 0;

  // Stimulus bookkeeping for the current phase.
  bit is_live[0:2047];
  bit paired [0:2047];
  int live[$];

  function automatic int in_use(int x);
    int n;
    n = (vcount_reg > NV) ? NV : vcount_reg;
    return (x >= 1 && x <= n) ? x : 0;
  endfunction

  function automatic void row_bounds(int v, output int b, output int e);
    int lo, hi;
    lo = row_tab[v];
    hi = row_tab[v+1];
    if (hi > NADJ) hi = NADJ;
    if (lo > hi) lo = hi;
    b = lo;
    e = hi;
  endfunction

  function automatic void relink(int x, int y, longint w);
    mate_tab[in_use(mate_tab[x])] = '0;
    mate_tab[in_use(mate_tab[y])] = '0;
    mate_w[in_use(mate_tab[x])] = 0;
    mate_w[in_use(mate_tab[y])] = 0;
    mate_tab[x] = vid_t'(y);
    mate_tab[y] = vid_t'(x);
    mate_w[x] = w;
    mate_w[y] = w;
  endfunction

  // Apply one accepted request to the predictor state and return its result.
  function automatic result_t improve_step(request_t r);
    result_t o;
    int v, s1, b, e, j, x, mx, ip, s1p, p1, p2, up1, si;
    longint wip, ws1p, best, gain, w1, w2, wp1, wp2, uw1, uwp1;
    o = '0;
    ip = 0; s1p = 0; p1 = 0; p2 = 0;
    wip = 0; ws1p = 0; w1 = 0; w2 = 0; wp1 = 0; wp2 = 0;
    si = r.slot;
    case (r.kind)
      REQ_LOAD_ROW: begin
        if (si <= NV + 1) row_tab[si] = r.rs;
        return o;
      end
      REQ_LOAD_ADJ: begin
        if (si < NADJ) begin
          adj_to[si] = r.id;
          adj_w[si] = longint'($signed(r.w));
        end
        return o;
      end
      REQ_LOAD_MATE: begin
        if (si <= NV) begin
          mate_tab[si] = r.id;
          mate_w[si] = longint'($signed(r.w));
        end
        return o;
      end
      REQ_PROCESS, REQ_READ: ;
      default: return o;
    endcase
    v = in_use(r.id);
    if (v == 0) return o;
    if (r.kind == REQ_READ) begin
      o.partner = mate_tab[v];
      o.pw = 32'(mate_w[v]);
      return o;
    end

    s1 = in_use(mate_tab[v]);
    best = mate_w[v];
    // rings through s1: mark v's neighbors, then look for them as partners of s1's
    if (s1 != 0) begin
      row_bounds(v, b, e);
      for (j = b; j < e; j++) begin
        x = in_use(adj_to[j]);
        if (x == 0) continue;
        mark_by[x] = vid_t'(v);
        mark_w[x] = adj_w[j];
      end
      row_bounds(s1, b, e);
      for (j = b; j < e; j++) begin
        x = in_use(adj_to[j]);
        if (x == 0 || x == v) continue;
        mx = in_use(mate_tab[x]);
        if (mark_by[mx] != v) continue;
        gain = adj_w[j] - mate_w[x] + mark_w[mx];
        if (gain > best) begin
          best = gain;
          ip = mx; wip = mark_w[mx];
          s1p = x; ws1p = adj_w[j];
        end
      end
    end

    // best and second-best arm from v
    row_bounds(v, b, e);
    for (j = b; j < e; j++) begin
      x = in_use(adj_to[j]);
      if (x == 0 || x == s1) continue;
      gain = adj_w[j] - mate_w[x];
      if (gain <= w2) continue;
      if (gain > w1) begin
        w2 = w1; p2 = p1; wp2 = wp1;
        w1 = gain; p1 = x; wp1 = adj_w[j];
      end else begin
        w2 = gain; p2 = x; wp2 = adj_w[j];
      end
    end
    if (w1 > best) begin
      best = w1; ip = p1; wip = wp1;
    end

    // path: an arm of s1 joined with an arm of v that does not collide
    if (s1 != 0) begin
      row_bounds(s1, b, e);
      for (j = b; j < e; j++) begin
        x = in_use(adj_to[j]);
        if (x == 0 || x == v) continue;
        gain = adj_w[j] - mate_w[x];
        if (gain < 0) continue;
        if (x == p1) begin
          up1 = p2; uw1 = w2; uwp1 = wp2;
        end else begin
          up1 = p1; uw1 = w1; uwp1 = wp1;
        end
        if (gain + uw1 > best) begin
          best = gain + uw1;
          ip = up1; wip = uwp1;
          s1p = x; ws1p = adj_w[j];
        end
      end
    end

    if (best > mate_w[v]) begin
      if (ip == s1) begin
        o.fault = 1'b1;
      end else begin
        o.changed = 1'b1;
        if (ip != 0) relink(v, ip, wip);
        if (s1p != 0) relink(s1, s1p, ws1p);
      end
    end
    o.partner = mate_tab[v];
    o.pw = 32'(mate_w[v]);
    o.oldp = vid_t'(s1);
    o.oldp_mate = (s1 != 0) ? vid_t'(in_use(mate_tab[s1])) : '0;
    return o;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("MISMATCH t=%0t %s: got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Sample both channels and the config port at the rising edge.
  always @(posedge clk) begin
    request_t r;
    result_t  x;
    in_took <= in_if.valid && in_if.ready;
    if (rst_n) begin
      if (cfg_we) vcount_reg = cfg_wdata;
      if (out_if.valid && out_if.ready) begin
        if (pending_results.size() == 0) begin
          report("result with nothing pending", out_if.vertex_partner, 0);
        end else begin
          x = pending_results.pop_front();
          if (out_if.changed !== x.changed) report("changed", out_if.changed, x.changed);
          if (out_if.vertex_partner !== x.partner)
            report("vertex_partner", out_if.vertex_partner, x.partner);
          if (out_if.partner_weight !== x.pw)
            report("partner_weight", $signed(out_if.partner_weight), $signed(x.pw));
          if (out_if.old_partner !== x.oldp)
            report("old_partner", out_if.old_partner, x.oldp);
          if (out_if.old_partner_new_mate !== x.oldp_mate)
            report("old_partner_new_mate", out_if.old_partner_new_mate, x.oldp_mate);
          if (out_if.fault !== x.fault) report("fault", out_if.fault, x.fault);
        end
      end
      if (in_if.valid && in_if.ready) begin
        r = '{in_if.req_type, in_if.slot, in_if.vertex_id, in_if.row_start,
              in_if.edge_weight};
        x = improve_step(r);
        pending_results.push_back(x);
        n_items++;
        if (r.kind == REQ_PROCESS && in_use(r.id) != 0) begin
          n_proc++;
          n_changed += x.changed;
          n_fault += x.fault;
        end
        if (r.kind == REQ_READ) n_reads++;
      end
    end
  end

  // Driver and result-side stalls: change at the falling edge.
  always @(negedge clk) begin
    request_t nxt;
    if (rst_n && (!in_if.valid || in_took)) begin
      if (request_q.size() > 0 && (calm || $urandom_range(0, 99) >= 12)) begin
        nxt = request_q.pop_front();
        in_if.valid       <= 1'b1;
        in_if.req_type    <= nxt.kind;
        in_if.slot        <= nxt.slot;
        in_if.vertex_id   <= nxt.id;
        in_if.row_start   <= nxt.rs;
        in_if.edge_weight <= nxt.w;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && (calm || $urandom_range(0, 99) >= 12);
  end

  task automatic put(req_code_t k, int s, int id, int rs, logic [31:0] w);
    request_q.push_back('{k, slot_t'(s), vid_t'(id), slot_t'(rs), w});
  endtask

  function automatic logic [31:0] pick_weight();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'h7fff_ffff;
    if (r == 1) return 32'h8000_0000;
    return 32'($urandom_range(0, 1 << 21)) - 32'(1 << 20);
  endfunction

  function automatic int pick_bad(int n);
    if (n >= 2047 || $urandom_range(0, 1)) return 0;
    return $urandom_range(n + 1, 2047);
  endfunction

  // Hold until every item is accepted and every result has come back.
  task automatic drain();
    while (request_q.size() != 0 || in_if.valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_count(int val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = ID_W'(val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // One phase: set the count, load a fresh random graph over a live vertex
  // set, then mostly process and read live vertices, with some noise.
  task automatic run_phase(int count, int n_ops);
    request_t loads[$];
    int n, k, cursor, v, deg, j, nb, u, r, tries;
    logic [31:0] mw;
    drain();
    set_count(count);
    n = (count > NV) ? NV : count;
    foreach (is_live[i]) begin
      is_live[i] = 1'b0;
      paired[i] = 1'b0;
    end
    live.delete();
    k = (n < 14) ? n : $urandom_range(6, 14);
    is_live[1] = 1'b1;
    is_live[n] = 1'b1;
    while (live.size() < 2) begin
      live.delete();
      for (int i = 1; i <= n; i++) if (is_live[i]) live.push_back(i);
      if (n == 1) break;
    end
    while (live.size() < k) begin
      v = $urandom_range(1, n);
      if (!is_live[v]) begin
        is_live[v] = 1'b1;
        live.push_back(v);
      end
    end
    live.sort();

    cursor = $urandom_range(0, 200);
    foreach (live[i]) begin
      v = live[i];
      if (!(v > 1 && is_live[v-1]))
        loads.push_back('{REQ_LOAD_ROW, slot_t'(v), vid_t'($urandom), slot_t'(cursor), pick_weight()});
      deg = $urandom_range(0, 6);
      if (!is_live[v+1] && cursor > 0 && $urandom_range(0, 11) == 0) begin
        // reversed row: no neighbors
        loads.push_back('{REQ_LOAD_ROW, slot_t'(v + 1), vid_t'($urandom), slot_t'(cursor - 1),
                          pick_weight()});
      end else begin
        for (j = 0; j < deg; j++) begin
          nb = ($urandom_range(0, 9) == 0) ? pick_bad(count)
                                           : live[$urandom_range(0, live.size() - 1)];
          loads.push_back('{REQ_LOAD_ADJ, slot_t'(cursor + j), vid_t'(nb), slot_t'($urandom),
                            pick_weight()});
        end
        cursor += deg;
        loads.push_back('{REQ_LOAD_ROW, slot_t'(v + 1), vid_t'($urandom), slot_t'(cursor),
                          pick_weight()});
        if (!is_live[v+1]) cursor += $urandom_range(0, 3);
      end
    end

    foreach (live[i]) begin
      v = live[i];
      if (paired[v]) continue;
      mw = 32'($urandom_range(0, 1 << 19)) - 32'(1 << 17);
      r = $urandom_range(0, 11);
      u = 0;
      if (r == 2) u = pick_bad(count);
      else if (r == 3) u = live[$urandom_range(0, live.size() - 1)];
      else if (r > 3) begin
        for (tries = 0; tries < 8 && u == 0; tries++) begin
          nb = live[$urandom_range(0, live.size() - 1)];
          if (nb != v && !paired[nb]) u = nb;
        end
        if (u != 0) begin
          paired[u] = 1'b1;
          loads.push_back('{REQ_LOAD_MATE, slot_t'(u), vid_t'(v), slot_t'($urandom), mw});
        end
      end
      paired[v] = 1'b1;
      loads.push_back('{REQ_LOAD_MATE, slot_t'(v), vid_t'(u), slot_t'($urandom), mw});
    end
    loads.shuffle();
    foreach (loads[i]) request_q.push_back(loads[i]);

    for (j = 0; j < n_ops; j++) begin
      r = $urandom_range(0, 99);
      v = live[$urandom_range(0, live.size() - 1)];
      if (r < 68) put(REQ_PROCESS, $urandom, v, $urandom, $urandom);
      else if (r < 80) put(REQ_READ, $urandom, v, $urandom, $urandom);
      else if (r < 84)
        put(REQ_LOAD_MATE, v, ($urandom_range(0, 3) == 0) ? 0 : live[$urandom_range(0, live.size() - 1)],
            $urandom, pick_weight());
      else if (r < 88)
        put($urandom_range(0, 1) ? REQ_PROCESS : REQ_READ, $urandom, pick_bad(count), $urandom, $urandom);
      else if (r < 92)
        put(req_code_t'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), $urandom, $urandom, $urandom,
            $urandom);
      else begin
        // loads aimed past the end of their store are dropped
        case ($urandom_range(0, 2))
          0: put(REQ_LOAD_ROW, $urandom_range(NV + 2, 16383), $urandom, $urandom, $urandom);
          1: put(REQ_LOAD_ADJ, $urandom_range(NADJ, 16383), $urandom, $urandom, $urandom);
          default: put(REQ_LOAD_MATE, $urandom_range(NV + 1, 16383), $urandom, $urandom, $urandom);
        endcase
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_LOAD_ROW;
    in_if.slot = '0;
    in_if.vertex_id = '0;
    in_if.row_start = '0;
    in_if.edge_weight = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    foreach (mark_by[i]) mark_by[i] = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    set_count(NV);
    // Directed: path 1-2-3 with an inconsistent matching gives a fault
    put(REQ_LOAD_ROW, 1, 0, 0, '0);
    put(REQ_LOAD_ROW, 2, 0, 1, '0);
    put(REQ_LOAD_ROW, 3, 0, 2, '0);
    put(REQ_LOAD_ROW, 4, 0, 2, '0);
    put(REQ_LOAD_ADJ, 0, 2, 0, 32'h000a_0000);
    put(REQ_LOAD_ADJ, 1, 3, 0, 32'h000a_0000);
    put(REQ_LOAD_MATE, 1, 2, 0, '0);
    put(REQ_LOAD_MATE, 2, 3, 0, '0);
    put(REQ_LOAD_MATE, 3, 2, 0, '0);
    // top vertices: reversed row for 1022, row of 1024 cut at the store end
    put(REQ_LOAD_ROW, 1022, 0, 100, '0);
    put(REQ_LOAD_ROW, 1023, 0, 50, '0);
    put(REQ_LOAD_ROW, 1024, 0, 8190, '0);
    put(REQ_LOAD_ROW, 1025, 0, 16383, '0);
    put(REQ_LOAD_ADJ, 8190, 1, 0, 32'h7fff_ffff);
    put(REQ_LOAD_ADJ, 8191, 2, 0, 32'h8000_0000);
    put(REQ_LOAD_MATE, 1022, 1024, 0, 32'hfffb_0000);
    put(REQ_LOAD_MATE, 1024, 1022, 0, 32'hfffb_0000);
    put(REQ_PROCESS, 0, 1, 0, '0);
    put(REQ_PROCESS, 0, 2, 0, '0);
    put(REQ_PROCESS, 0, 1024, 0, '0);
    put(REQ_PROCESS, 0, 1022, 0, '0);
    put(REQ_READ, 0, 1022, 0, '0);
    put(REQ_READ, 16383, 1, 16383, 32'hffff_ffff);
    put(REQ_PROCESS, 0, 0, 0, '0);
    put(REQ_PROCESS, 0, 2047, 0, '0);
    put(REQ_READ, 0, 0, 0, '0);
    put(REQ_SPARE_HI, 16383, 2047, 16383, 32'hffff_ffff);
    put(REQ_LOAD_ROW, 16383, 2047, 16383, 32'h8000_0000);
    put(REQ_LOAD_ADJ, 8192, 5, 0, 32'h1234_5678);
    put(REQ_LOAD_MATE, 1025, 7, 0, 32'h7fff_ffff);

    run_phase(2, 140);
    run_phase(1, 60);
    calm = 1'b1;
    run_phase(37, 180);
    calm = 1'b0;
    run_phase(2047, 200);
    run_phase(300, 200);
    run_phase(1024, 200);
    run_phase(5, 150);
    drain();
    repeat (200) @(negedge clk);

    if (pending_results.size() != 0)
      report("results never delivered", 0, pending_results.size());
    $display("Covered %0d items over 8 phases: %0d vertex updates (%0d rewired, %0d faults),",
             n_items, n_proc, n_changed, n_fault);
    $display("%0d partner reads, vertex counts 1 to 2047; %0d mismatches.", n_reads, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40_000_000;
    $display("Timeout: %0d results still pending", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
